>>> src/abf_pkg.sv
`timescale 1ns / 1ps
// abf_pkg: shared types and codes for the span fill engine
// used by abf_ctrl, abf_dp and alpha_blend_span_fill
package abf_pkg;
	typedef enum logic [2:0] {
		FN_HSPAN = 3'd0,
		FN_VSPAN = 3'd1,
		FN_RECT  = 3'd2,
		FN_BG    = 3'd3,
		FN_READ  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_RDWAIT,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_X0 = 3'd0;
	localparam logic [2:0] REG_Y0 = 3'd1;
	localparam logic [2:0] REG_X1 = 3'd2;
	localparam logic [2:0] REG_Y1 = 3'd3;
	localparam logic [2:0] REG_BG = 3'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic rd_issue;
		logic rd_cap;
		logic clr_empty;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic empty_box;
		logic last_px;
		logic is_read;
		logic is_bg;
		logic store_empty;
	} sts_t;

	function automatic logic [7:0] mix(input logic [7:0] old, input logic [7:0] c,
			input logic [7:0] a);
		logic [16:0] s;
		logic [25:0] p;
		logic [8:0] q;
		logic [16:0] r;
		s = 17'(({8'd0, 8'd255 - a}) * 16'(old)) + 17'(16'(c) * 16'(a)) + 17'd127;
		p = 26'(s) * 26'd257;
		q = 9'(p >> 16);
		r = s - 17'(q) * 17'd255;
		if (r >= 17'd255) q = q + 9'd1;
		return q[7:0];
	endfunction
endpackage

>>> src/abf_ram.sv
`timescale 1ns / 1ps
// abf_ram: generic single write, single registered read memory
// no dependencies
module abf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> src/abf_dp.sv
`timescale 1ns / 1ps
// abf_dp: clipping, pixel walk, blend pipeline and pixel store
// depends on abf_pkg and abf_ram
module abf_dp #(
	parameter int BUF_W = 64,
	parameter int BUF_H = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  abf_pkg::cmd_t       cmd,
	output abf_pkg::sts_t       sts,
	input  logic [2:0]          func,
	input  logic signed [15:0]  start_x,
	input  logic signed [15:0]  start_y,
	input  logic signed [15:0]  end_x,
	input  logic signed [15:0]  end_y,
	input  logic [31:0]         color_rgba,
	input  logic signed [15:0]  area_x0,
	input  logic signed [15:0]  area_y0,
	input  logic signed [15:0]  area_x1,
	input  logic signed [15:0]  area_y1,
	input  logic [23:0]         background_rgb,
	output logic [23:0]         read_rgb
);
	localparam int DEPTH = BUF_W * BUF_H;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(BUF_W + 1);
	localparam int YW = $clog2(BUF_H + 1);

	// clip bounds in absolute 18-bit signed coordinate space
	logic signed [17:0] ex1, ey1, bx0, by0, bx1, by1;
	logic signed [17:0] sx, sy, exx, eyy, ax0, ay0;
	logic fn_ok, box_empty;

	always_comb begin
		ax0 = 18'(area_x0);
		ay0 = 18'(area_y0);
		ex1 = (18'(area_x1) < ax0 + 18'(BUF_W)) ? 18'(area_x1) : ax0 + 18'(BUF_W);
		ey1 = (18'(area_y1) < ay0 + 18'(BUF_H)) ? 18'(area_y1) : ay0 + 18'(BUF_H);
		sx = 18'(start_x);
		sy = 18'(start_y);
		exx = 18'(end_x);
		eyy = 18'(end_y);
		fn_ok = 1'b1;
		unique case (func)
			abf_pkg::FN_HSPAN: begin
				eyy = sy;
				fn_ok = (sy >= ay0) && (sy < ey1);
			end
			abf_pkg::FN_VSPAN: begin
				exx = sx;
				fn_ok = (sx >= ax0) && (sx < ex1);
			end
			abf_pkg::FN_BG: begin
				sx = ax0;
				sy = ay0;
				exx = ex1 - 18'sd1;
				eyy = ey1 - 18'sd1;
			end
			abf_pkg::FN_READ: begin
				exx = sx;
				eyy = sy;
			end
			abf_pkg::FN_RECT: ;
			default: fn_ok = 1'b0;
		endcase
		bx0 = (sx > ax0) ? sx : ax0;
		by0 = (sy > ay0) ? sy : ay0;
		bx1 = (exx + 18'sd1 < ex1) ? exx + 18'sd1 : ex1;
		by1 = (eyy + 18'sd1 < ey1) ? eyy + 18'sd1 : ey1;
		box_empty = !fn_ok || (bx0 >= bx1) || (by0 >= by1);
	end

	logic [XW-1:0] cx_q, x0_q, x1_q;
	logic [YW-1:0] cy_q, y1_q;
	logic [31:0] col_q;
	logic [23:0] bg_q;
	logic [23:0] res_q;
	logic is_bg_q, is_read_q, empty_q, store_empty_q;
	logic [AW-1:0] addr;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= XW'(bx0 - ax0);
			cx_q <= XW'(bx0 - ax0);
			cy_q <= YW'(by0 - ay0);
			x1_q <= XW'(bx1 - ax0);
			y1_q <= YW'(by1 - ay0);
			col_q <= color_rgba;
			bg_q <= background_rgb;
		end else if (cmd.step) begin
			if (cx_q + XW'(1) == x1_q) begin
				cx_q <= x0_q;
				cy_q <= cy_q + YW'(1);
			end else begin
				cx_q <= cx_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_bg_q <= 1'b0;
			is_read_q <= 1'b0;
			empty_q <= 1'b1;
			store_empty_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				is_bg_q <= (func == abf_pkg::FN_BG);
				is_read_q <= (func == abf_pkg::FN_READ);
				empty_q <= box_empty;
			end
			if (cmd.clr_empty) store_empty_q <= 1'b0;
		end
	end

	assign addr = AW'(32'(cy_q) * BUF_W + 32'(cx_q));

	// blend pipeline: read issued on step, s1 data back, s2 blended and written
	logic v_s1, v_s2, bgw_s1, bgw_s2;
	logic [AW-1:0] a_s1, a_s2;
	logic [23:0] rdata, wdata;
	logic [23:0] blend_s2;
	logic we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= addr;
		a_s2 <= a_s1;
		bgw_s1 <= is_bg_q;
		bgw_s2 <= bgw_s1;
		blend_s2 <= rdata;
		if (cmd.rd_cap) res_q <= empty_q ? 24'd0 : rdata;
		else if (cmd.load) res_q <= 24'd0;
		if (cmd.publish) read_rgb <= res_q;
	end

	assign we = v_s2;
	assign wdata = bgw_s2 ? bg_q : {abf_pkg::mix(blend_s2[23:16], col_q[31:24], col_q[7:0]),
		abf_pkg::mix(blend_s2[15:8], col_q[23:16], col_q[7:0]),
		abf_pkg::mix(blend_s2[7:0], col_q[15:8], col_q[7:0])};

	abf_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(a_s2), .wdata(wdata), .raddr(addr), .rdata(rdata)
	);

	assign sts.empty_box = empty_q;
	assign sts.last_px = (cx_q + XW'(1) == x1_q) && (cy_q + YW'(1) == y1_q);
	assign sts.is_read = is_read_q;
	assign sts.is_bg = is_bg_q;
	assign sts.store_empty = store_empty_q;
endmodule

>>> src/abf_ctrl.sv
`timescale 1ns / 1ps
// abf_ctrl: command sequencer for the span fill engine
// depends on abf_pkg
module abf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  abf_pkg::sts_t sts,
	output abf_pkg::cmd_t cmd,
	output logic          in_ready,
	output logic          out_valid
);
	abf_pkg::state_t st_q, st_d;
	logic pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= abf_pkg::ST_IDLE;
			pend_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == abf_pkg::ST_DRAIN && st_d == abf_pkg::ST_OUT) pend_q <= 1'b1;
			else if (out_fire) pend_q <= 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			abf_pkg::ST_IDLE:   if (in_fire) st_d = abf_pkg::ST_SETUP;
			abf_pkg::ST_SETUP: begin
				if (sts.empty_box || (sts.is_bg && !sts.store_empty)) st_d = abf_pkg::ST_DRAIN;
				else if (sts.is_read) st_d = abf_pkg::ST_RDWAIT;
				else st_d = abf_pkg::ST_WALK;
			end
			abf_pkg::ST_WALK:   if (sts.last_px) st_d = abf_pkg::ST_DRAIN;
			abf_pkg::ST_RDWAIT: st_d = abf_pkg::ST_DRAIN;
			abf_pkg::ST_DRAIN:  if (!pend_q) st_d = abf_pkg::ST_OUT;
			abf_pkg::ST_OUT:    st_d = abf_pkg::ST_IDLE;
			default:            st_d = abf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (st_q)
			abf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			abf_pkg::ST_SETUP:
				cmd.clr_empty = sts.is_bg;
			abf_pkg::ST_WALK:   cmd.step = 1'b1;
			abf_pkg::ST_RDWAIT: cmd.rd_cap = 1'b1;
			abf_pkg::ST_DRAIN:  cmd.publish = !pend_q;
			default: ;
		endcase
	end

	assign out_valid = pend_q;
endmodule

>>> src/alpha_blend_span_fill.sv
`timescale 1ns / 1ps
// alpha_blend_span_fill: top level, apb registers and stream ports
// depends on abf_pkg, abf_ctrl, abf_dp, abf_ram
//
// Each command takes one word and returns one word. A command walks its
// clipped pixels one per cycle through a simple dual-port store with a two
// stage read-blend-write pipeline. A result word waits in an output register
// while the next command is already accepted and run; that command's result
// is held back until the earlier word has been taken.
module alpha_blend_span_fill #(
	parameter int BUF_W = 64,
	parameter int BUF_H = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func, start_x, start_y, end_x, end_y, color_rgba, then 5 unused bits
	input  logic [103:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_rgb
	output logic [23:0] m_tdata
);
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic [23:0] bg_q;
	abf_pkg::cmd_t cmd;
	abf_pkg::sts_t sts;
	logic in_fire, out_fire, wr;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= 16'sd0;
			y0_q <= 16'sd0;
			x1_q <= 16'sd64;
			y1_q <= 16'sd64;
			bg_q <= 24'hffffff;
		end else if (wr && paddr[1:0] == 2'd0) begin
			unique case (ridx)
				abf_pkg::REG_X0: x0_q <= pwdata[15:0];
				abf_pkg::REG_Y0: y0_q <= pwdata[15:0];
				abf_pkg::REG_X1: x1_q <= pwdata[15:0];
				abf_pkg::REG_Y1: y1_q <= pwdata[15:0];
				abf_pkg::REG_BG: bg_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			abf_pkg::REG_X0: prdata = {{16{x0_q[15]}}, x0_q};
			abf_pkg::REG_Y0: prdata = {{16{y0_q[15]}}, y0_q};
			abf_pkg::REG_X1: prdata = {{16{x1_q[15]}}, x1_q};
			abf_pkg::REG_Y1: prdata = {{16{y1_q[15]}}, y1_q};
			abf_pkg::REG_BG: prdata = {8'd0, bg_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign in_fire = s_tvalid & s_tready;
	assign out_fire = m_tvalid & m_tready;

	abf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
	);

	abf_dp #(.BUF_W(BUF_W), .BUF_H(BUF_H)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(s_tdata[2:0]), .start_x(s_tdata[18:3]), .start_y(s_tdata[34:19]),
		.end_x(s_tdata[50:35]), .end_y(s_tdata[66:51]), .color_rgba(s_tdata[98:67]),
		.area_x0(x0_q), .area_y0(y0_q), .area_x1(x1_q), .area_y1(y1_q),
		.background_rgb(bg_q), .read_rgb(m_tdata)
	);
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for alpha_blend_span_fill, drives commands and window
// settings and checks every result word against an in-bench pixel store model
// depends on abf_pkg and alpha_blend_span_fill
module tb;
	localparam int STORE_W = 64;
	localparam int STORE_H = 64;
	localparam int CYCLE_LIMIT = 3000000;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	// func, start_x, start_y, end_x, end_y, color_rgba, zero fill
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// read_rgb
	logic [23:0]  m_tdata;

	alpha_blend_span_fill #(.BUF_W(STORE_W), .BUF_H(STORE_H)) dut (.*);

	// model state
	logic [23:0] pix_model [STORE_W*STORE_H];
	bit          model_empty;
	int          win_x0, win_y0, win_x1, win_y1;
	logic [23:0] bg_color;

	logic [23:0] pending_rgb [$];
	int          n_fail;
	int          cycles;
	bit          quiet;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int clip_x1();
		return (win_x1 < win_x0 + STORE_W) ? win_x1 : win_x0 + STORE_W;
	endfunction

	function automatic int clip_y1();
		return (win_y1 < win_y0 + STORE_H) ? win_y1 : win_y0 + STORE_H;
	endfunction

	function automatic logic [7:0] blend8(int old, int c, int a);
		return 8'(((255 - a) * old + c * a + 127) / 255);
	endfunction

	function automatic void blend_area(int xs, int ys, int xe, int ye, logic [31:0] rgba);
		int lx, ly, hx, hy, idx;
		logic [23:0] p;
		lx = xs > win_x0 ? xs : win_x0;
		ly = ys > win_y0 ? ys : win_y0;
		hx = clip_x1();
		hy = clip_y1();
		if (xe + 1 < hx) hx = xe + 1;
		if (ye + 1 < hy) hy = ye + 1;
		for (int y = ly; y < hy; y++)
			for (int x = lx; x < hx; x++) begin
				idx = (y - win_y0) * STORE_W + (x - win_x0);
				if (idx < 0 || idx >= STORE_W*STORE_H) continue;
				p = pix_model[idx];
				pix_model[idx] = {blend8(p[23:16], rgba[31:24], rgba[7:0]),
					blend8(p[15:8], rgba[23:16], rgba[7:0]),
					blend8(p[7:0], rgba[15:8], rgba[7:0])};
			end
	endfunction

	function automatic logic [23:0] run_command(logic [2:0] fn, logic [15:0] sx,
			logic [15:0] sy, logic [15:0] ex, logic [15:0] ey, logic [31:0] rgba);
		int xs, ys, xe, ye, idx;
		logic [23:0] res;
		xs = int'(signed'(sx));
		ys = int'(signed'(sy));
		xe = int'(signed'(ex));
		ye = int'(signed'(ey));
		res = '0;
		case (fn)
			abf_pkg::FN_HSPAN:
				if (ys >= win_y0 && ys < clip_y1()) blend_area(xs, ys, xe, ys, rgba);
			abf_pkg::FN_VSPAN:
				if (xs >= win_x0 && xs < clip_x1()) blend_area(xs, ys, xs, ye, rgba);
			abf_pkg::FN_RECT:
				blend_area(xs, ys, xe, ye, rgba);
			abf_pkg::FN_BG:
				if (model_empty) begin
					for (int y = win_y0; y < clip_y1(); y++)
						for (int x = win_x0; x < clip_x1(); x++) begin
							idx = (y - win_y0) * STORE_W + (x - win_x0);
							if (idx >= 0 && idx < STORE_W*STORE_H) pix_model[idx] = bg_color;
						end
					model_empty = 0;
				end
			abf_pkg::FN_READ:
				if (xs >= win_x0 && xs < clip_x1() && ys >= win_y0 && ys < clip_y1()) begin
					idx = (ys - win_y0) * STORE_W + (xs - win_x0);
					if (idx >= 0 && idx < STORE_W*STORE_H) res = pix_model[idx];
				end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_command(logic [2:0] fn, int sx, int sy, int ex, int ey,
			logic [31:0] rgba);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, rgba, 16'(ey), 16'(ex), 16'(sy), 16'(sx), fn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_rgb.push_back(run_command(fn, 16'(sx), 16'(sy), 16'(ex), 16'(ey), rgba));
	endtask

	// result side
	initial begin
		int stall;
		logic [23:0] want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_rgb.size() == 0) begin
				n_fail++;
				if (n_fail <= 10) $display("unexpected word %h", m_tdata);
			end else begin
				want = pending_rgb.pop_front();
				if (m_tdata !== want) begin
					n_fail++;
					if (n_fail <= 10) $display("read_rgb mismatch: exp %h got %h", want, m_tdata);
				end
			end
		end
	end

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			abf_pkg::REG_X0: win_x0 = int'(signed'(val[15:0]));
			abf_pkg::REG_Y0: win_y0 = int'(signed'(val[15:0]));
			abf_pkg::REG_X1: win_x1 = int'(signed'(val[15:0]));
			abf_pkg::REG_Y1: win_y1 = int'(signed'(val[15:0]));
			abf_pkg::REG_BG: bg_color = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_window(int x0, int y0, int x1, int y1);
		wait_idle();
		write_reg(abf_pkg::REG_X0, 32'(x0));
		write_reg(abf_pkg::REG_Y0, 32'(y0));
		write_reg(abf_pkg::REG_X1, 32'(x1));
		write_reg(abf_pkg::REG_Y1, 32'(y1));
	endtask

	function automatic int near_coord(int lo, int hi);
		if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
		if (hi < lo) hi = lo;
		return $urandom_range(0, hi - lo + 16) + lo - 8;
	endfunction

	task automatic test_before_fill();
		send_command(abf_pkg::FN_READ, -1, 0, 0, 0, 32'hffffffff);
		send_command(abf_pkg::FN_READ, 64, 63, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 32767, -32768, 0, 0, 32'h0);
		send_command(abf_pkg::FN_HSPAN, 0, 64, 63, 0, 32'hffffffff);
		send_command(abf_pkg::FN_HSPAN, 0, -1, 63, 0, 32'hffffffff);
		send_command(abf_pkg::FN_VSPAN, -32768, 0, 0, 63, 32'h12345678);
		send_command(abf_pkg::FN_HSPAN, 40, 5, 10, 0, 32'hffffffff);
		send_command(abf_pkg::FN_RECT, 10, 10, 9, 20, 32'hffffffff);
		send_command(3'd5, 0, 0, 63, 63, 32'hffffffff);
		send_command(3'd6, 1, 1, 1, 1, 32'h0);
		send_command(3'd7, -1, -1, -1, -1, 32'hffffffff);
	endtask

	task automatic test_background();
		wait_idle();
		write_reg(abf_pkg::REG_BG, 32'h00a5_5a3c);
		send_command(abf_pkg::FN_BG, 0, 0, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 0, 0, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 63, 63, 0, 0, 32'h0);
		wait_idle();
		write_reg(abf_pkg::REG_BG, 32'h0000_0000);
		send_command(abf_pkg::FN_BG, 0, 0, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 17, 42, 0, 0, 32'h0);
	endtask

	task automatic test_directed();
		send_command(abf_pkg::FN_RECT, -32768, -32768, 32767, 32767, 32'h00ff0080);
		send_command(abf_pkg::FN_HSPAN, -5, 3, 100, 0, 32'hffffffff);
		send_command(abf_pkg::FN_VSPAN, 7, -10, 0, 200, 32'hff000000);
		send_command(abf_pkg::FN_HSPAN, 0, 0, 63, 0, 32'h123456ff);
		send_command(abf_pkg::FN_RECT, 20, 20, 22, 21, 32'habcdef7f);
		send_command(abf_pkg::FN_READ, 0, 3, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 7, 40, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 0, 0, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 21, 21, 0, 0, 32'h0);
		send_command(abf_pkg::FN_READ, 63, 0, 0, 0, 32'h0);
	endtask

	task automatic test_random(int count);
		int fn_pick, sx, sy, ex, ey, ux, uy;
		logic [2:0] fn;
		logic [31:0] rgba;
		ux = clip_x1();
		uy = clip_y1();
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
			fn_pick = $urandom_range(0, 99);
			if (fn_pick < 30) fn = abf_pkg::FN_HSPAN;
			else if (fn_pick < 50) fn = abf_pkg::FN_VSPAN;
			else if (fn_pick < 65) fn = abf_pkg::FN_RECT;
			else if (fn_pick < 92) fn = abf_pkg::FN_READ;
			else if (fn_pick < 94) fn = abf_pkg::FN_BG;
			else fn = 3'($urandom_range(5, 7));
			sx = near_coord(win_x0, ux - 1);
			sy = near_coord(win_y0, uy - 1);
			if (fn == abf_pkg::FN_RECT) begin
				ex = sx + $urandom_range(0, 14) - 2;
				ey = sy + $urandom_range(0, 10) - 2;
				if ($urandom_range(0, 40) == 0) begin
					ex = sx + 70;
					ey = sy + 70;
				end
			end else begin
				ex = sx + $urandom_range(0, 74) - 4;
				ey = sy + $urandom_range(0, 74) - 4;
			end
			if ($urandom_range(0, 15) == 0) ex = $urandom_range(0, 65535);
			if ($urandom_range(0, 15) == 0) ey = $urandom_range(0, 65535);
			rgba = $urandom;
			send_command(fn, sx, sy, ex, ey, rgba);
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		n_fail = 0;
		cycles = 0;
		quiet = 0;
		for (int i = 0; i < STORE_W*STORE_H; i++) pix_model[i] = '0;
		model_empty = 1;
		win_x0 = 0;
		win_y0 = 0;
		win_x1 = 64;
		win_y1 = 64;
		bg_color = 24'hffffff;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_fill();
		test_background();
		test_directed();
		test_random(300);
		set_window(-20, 100, 30, 300);
		test_random(250);
		set_window(-32768, -32768, 32767, 32767);
		test_random(250);
		set_window(32700, 32710, 32767, 32767);
		test_random(250);
		set_window(10, 10, 5, 40);
		test_random(80);
		set_window(5, 5, 5, 5);
		test_random(40);
		set_window(3, -7, 40, 20);
		test_random(250);
		wait_idle();
		write_reg(abf_pkg::REG_BG, 32'h00ff_ffff);
		set_window(0, 0, 64, 64);
		test_random(230);

		wait_idle();
		repeat (20) @(posedge clk);
		if (n_fail == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
